// File: rtl/core/assert_macros.svh
// Assertion macros shared by the heading fusion RTL.
// Depends on nothing; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Invariant that holds at every clock edge out of reset.
`define HCF_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error(msg);
// Consequence that must follow in the cycle after the trigger.
`define HCF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HCF_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define HCF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

// File: rtl/core/hcf_pkg.sv
// Package for the heading fusion block: field widths, register codes,
// reset values, divider constants and controller/datapath types. No dependencies.
`default_nettype none

package hcf_pkg;

  // word field widths
  localparam int RATE_W     = 16;
  localparam int INTERVAL_W = 20;
  localparam int HEAD_W     = 15;

  localparam int ANGLE_FRACTION_BITS_DEF = 6;

  // configuration registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int GAIN_W     = 13;
  localparam int BIAS_W     = 13;
  localparam int THR_W      = 15;
  localparam int OUTLIER_W  = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GYRO_BIAS        = 3'd0,
    CFG_MAG_FILTER_GAIN  = 3'd1,
    CFG_FUSE_GAIN_STILL  = 3'd2,
    CFG_FUSE_GAIN_MOVING = 3'd3,
    CFG_MOVING_THRESHOLD = 3'd4,
    CFG_OUTLIER_LIMIT    = 3'd5,
    CFG_MAX_INTERVAL     = 3'd6
  } cfg_idx_t;

  localparam logic signed [BIAS_W-1:0] RST_GYRO_BIAS     = 13'sd0;
  localparam logic [GAIN_W-1:0]        RST_MAG_GAIN      = 13'd901;
  localparam logic [GAIN_W-1:0]        RST_GAIN_STILL    = 13'd164;
  localparam logic [GAIN_W-1:0]        RST_GAIN_MOVING   = 13'd82;
  localparam logic [THR_W-1:0]         RST_MOVING_THR    = 15'd640;
  localparam logic [OUTLIER_W-1:0]     RST_OUTLIER_LIMIT = 14'd2240;
  localparam logic [INTERVAL_W-1:0]    RST_MAX_INTERVAL  = 20'd200000;

  // shared multiplier: 16 x 20 unsigned
  localparam int MUL_A_W = RATE_W;
  localparam int MUL_B_W = INTERVAL_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Q12 gains, round half away from zero on the magnitude
  localparam int Q12_SHIFT  = 12;
  localparam int ROUND_HALF = 1 << (Q12_SHIFT - 1);

  // divide by 1e6 = 2^6 * 15625: drop six bits, then long division by 15625
  localparam int DIV_PRESHIFT      = 6;
  localparam int DIV_DIVISOR       = 15625;
  localparam int DREM_W            = 14;
  localparam int QUO_W             = 17;
  localparam int DIV_BITS_PER_STEP = 3;
  localparam int DIV_STEPS         = (QUO_W + DIV_BITS_PER_STEP - 1) / DIV_BITS_PER_STEP;
  localparam int QSH_W             = DIV_BITS_PER_STEP * DIV_STEPS;
  localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_INTEG,
    S_JUMP,
    S_MUL_JUMP,
    S_CMP_UPD,
    S_ERR,
    S_MUL_ERR,
    S_FUSE_UPD,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_RATE,
    OP_DIV_STEP,
    OP_INTEG,
    OP_JUMP,
    OP_MUL_GAIN,
    OP_CMP_UPD,
    OP_ERR,
    OP_FUSE_UPD,
    OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   div_first;
  } dp_cmd_t;

  typedef struct packed {
    logic integ_en;
    logic present;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/hcf_channels.sv
// Valid/ready channel interfaces of the heading fusion block: input word,
// result word and register write. Depends on hcf_pkg.
`default_nettype none

interface hcf_in_if;
  import hcf_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [RATE_W-1:0]     raw_rate;
  logic        [INTERVAL_W-1:0] interval_us;
  logic                         compass_present;
  logic        [HEAD_W-1:0]     compass_heading;

  modport source (output valid, raw_rate, interval_us, compass_present, compass_heading,
                  input ready);
  modport sink   (input valid, raw_rate, interval_us, compass_present, compass_heading,
                  output ready);
endinterface

interface hcf_out_if;
  import hcf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic        [HEAD_W-1:0] fused_heading;
  logic                     fused_valid;
  logic        [HEAD_W-1:0] filtered_compass;
  logic signed [RATE_W-1:0] corrected_rate;

  modport source (output valid, fused_heading, fused_valid, filtered_compass,
                  corrected_rate, input ready);
  modport sink   (input valid, fused_heading, fused_valid, filtered_compass,
                  corrected_rate, output ready);
endinterface

interface hcf_cfg_if;
  import hcf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/core/hcf_dp.sv
// Datapath of the heading fusion block: registers, shared multiplier,
// constant divider, angle wrapping and result register. Depends on hcf_pkg.
`default_nettype none

module hcf_dp #(
  parameter int ANGLE_FRACTION_BITS = hcf_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hcf_pkg::dp_cmd_t                    cmd,
  output hcf_pkg::dp_stat_t                   stat,
  input  logic                                cfg_we,
  input  logic [hcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hcf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [hcf_pkg::RATE_W-1:0]   raw_rate,
  input  logic [hcf_pkg::INTERVAL_W-1:0]      interval_us,
  input  logic                                compass_present,
  input  logic [hcf_pkg::HEAD_W-1:0]          compass_heading,
  output logic [hcf_pkg::HEAD_W-1:0]          fused_heading,
  output logic                                fused_valid,
  output logic [hcf_pkg::HEAD_W-1:0]          filtered_compass,
  output logic signed [hcf_pkg::RATE_W-1:0]   corrected_rate
);
  import hcf_pkg::*;

  localparam int FULL_TURN  = 360 << ANGLE_FRACTION_BITS;
  localparam int HALF_TURN  = 180 << ANGLE_FRACTION_BITS;
  localparam int AW         = $clog2(FULL_TURN);
  localparam int SW         = AW + 2;
  localparam int MOD_W      = (AW > QUO_W) ? AW + 1 : QUO_W + 1;
  localparam int HEAD_STEPS = $clog2(((1 << HEAD_W) + FULL_TURN - 1) / FULL_TURN);
  localparam int STEP_STEPS = $clog2(((1 << QUO_W) + FULL_TURN - 1) / FULL_TURN);
  localparam int CMP_W      = (AW > OUTLIER_W) ? AW : OUTLIER_W;

  localparam logic signed [SW-1:0] FULL_S = SW'(FULL_TURN);
  localparam logic signed [SW-1:0] HALF_S = SW'(HALF_TURN);
  localparam logic signed [RATE_W:0] SAT_HI = (RATE_W+1)'((1 << (RATE_W - 1)) - 1);
  localparam logic signed [RATE_W:0] SAT_LO = (RATE_W+1)'(-(1 << (RATE_W - 1)));

  // base +/- delta, both inside one turn, wrapped back into one turn
  function automatic logic [AW-1:0] turn_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] delta,
                                             input logic          sub);
    logic [AW:0] t;
    if (sub) begin
      t = {1'b0, base} - {1'b0, delta};
      if (t[AW]) t = t + (AW+1)'(FULL_TURN);
    end else begin
      t = {1'b0, base} + {1'b0, delta};
      if (t >= (AW+1)'(FULL_TURN)) t = t - (AW+1)'(FULL_TURN);
    end
    return t[AW-1:0];
  endfunction

  // a - b wrapped into [-half turn, half turn)
  function automatic logic signed [SW-1:0] turn_diff(input logic [AW-1:0] a,
                                                     input logic [AW-1:0] b);
    logic signed [SW-1:0] d;
    d = signed'({2'b00, a}) - signed'({2'b00, b});
    if (d >= HALF_S) d = d - FULL_S;
    else if (d < -HALF_S) d = d + FULL_S;
    return d;
  endfunction

  // configuration registers
  logic signed [BIAS_W-1:0]  gyro_bias_r;
  logic [GAIN_W-1:0]         mag_gain_r;
  logic [GAIN_W-1:0]         gain_still_r;
  logic [GAIN_W-1:0]         gain_moving_r;
  logic [THR_W-1:0]          move_thr_r;
  logic [OUTLIER_W-1:0]      outlier_r;
  logic [INTERVAL_W-1:0]     max_int_r;

  // filter state
  logic [AW-1:0]             fused_r;
  logic [AW-1:0]             compass_r;
  logic                      fused_seeded_r;
  logic                      compass_seeded_r;

  // per-word working registers
  logic signed [RATE_W-1:0]  rate_r;
  logic [RATE_W-1:0]         mag_r;
  logic                      neg_r;
  logic [INTERVAL_W-1:0]     interval_r;
  logic                      present_r;
  logic [AW-1:0]             heading_r;
  logic                      integ_en_r;
  logic [PROD_W-1:0]         prod_r;
  logic [DREM_W-1:0]         rem_r;
  logic [QSH_W-1:0]          sh_r;
  logic [AW-1:0]             dmag_r;
  logic                      dneg_r;
  logic                      upd_r;
  logic [GAIN_W-1:0]         gain_r;

  // result register
  logic [HEAD_W-1:0]         fused_out_r;
  logic                      fvalid_out_r;
  logic [HEAD_W-1:0]         comp_out_r;
  logic signed [RATE_W-1:0]  rate_out_r;

  // combinational values
  logic signed [RATE_W:0]    rate_diff;
  logic signed [RATE_W-1:0]  rate_sat;
  logic [RATE_W-1:0]         mag_nxt;
  logic [AW-1:0]             heading_nxt;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [PROD_W-1:0]         prod_nxt;
  logic [DREM_W-1:0]         rem_nxt;
  logic [QSH_W-1:0]          sh_nxt;
  logic [AW-1:0]             step_mod;
  logic [AW-1:0]             rnd_mag;
  logic signed [SW-1:0]      jump_d;
  logic signed [SW-1:0]      err_d;
  logic [AW-1:0]             jump_mag;
  logic [AW-1:0]             err_mag;

  // bias removal, saturation and magnitude
  always_comb begin
    rate_diff = (RATE_W+1)'(raw_rate) - (RATE_W+1)'(gyro_bias_r);
    if (rate_diff > SAT_HI) rate_sat = RATE_W'(SAT_HI);
    else if (rate_diff < SAT_LO) rate_sat = RATE_W'(SAT_LO);
    else rate_sat = RATE_W'(rate_diff);
    mag_nxt = rate_sat[RATE_W-1] ? (RATE_W'(0) - RATE_W'(rate_sat)) : RATE_W'(rate_sat);
  end

  // reduce the incoming compass heading into one turn
  always_comb begin : head_reduce
    logic [MOD_W-1:0] v;
    v = MOD_W'(compass_heading);
    for (int k = HEAD_STEPS - 1; k >= 0; k--) begin
      if (v >= MOD_W'(FULL_TURN << k)) v = v - MOD_W'(FULL_TURN << k);
    end
    heading_nxt = AW'(v);
  end

  // reduce the integrated step into one turn
  always_comb begin : step_reduce
    logic [MOD_W-1:0] v;
    v = MOD_W'(sh_r[QUO_W-1:0]);
    for (int k = STEP_STEPS - 1; k >= 0; k--) begin
      if (v >= MOD_W'(FULL_TURN << k)) v = v - MOD_W'(FULL_TURN << k);
    end
    step_mod = AW'(v);
  end

  // shared multiplier
  always_comb begin
    if (cmd.op == OP_MUL_RATE) begin
      mul_a = mag_r;
      mul_b = interval_r;
    end else begin
      mul_a = MUL_A_W'(gain_r);
      mul_b = MUL_B_W'(dmag_r);
    end
    prod_nxt = mul_a * mul_b;
  end

  // restoring division by the divisor, several quotient bits a cycle
  always_comb begin : div_step
    logic [DREM_W:0] trial;
    rem_nxt = cmd.div_first ? DREM_W'(prod_r[PROD_W-1:DIV_PRESHIFT+QSH_W]) : rem_r;
    sh_nxt  = cmd.div_first ? prod_r[DIV_PRESHIFT+QSH_W-1:DIV_PRESHIFT] : sh_r;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      trial  = {rem_nxt, sh_nxt[QSH_W-1]};
      sh_nxt = {sh_nxt[QSH_W-2:0], 1'b0};
      if (trial >= (DREM_W+1)'(DIV_DIVISOR)) begin
        rem_nxt   = DREM_W'(trial - (DREM_W+1)'(DIV_DIVISOR));
        sh_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[DREM_W-1:0];
      end
    end
  end

  // Q12 rounding on the magnitude, angle differences
  always_comb begin
    rnd_mag  = AW'((prod_r + PROD_W'(ROUND_HALF)) >> Q12_SHIFT);
    jump_d   = turn_diff(heading_r, compass_r);
    err_d    = turn_diff(compass_r, fused_r);
    jump_mag = jump_d[SW-1] ? AW'(-jump_d) : AW'(jump_d);
    err_mag  = err_d[SW-1] ? AW'(-err_d) : AW'(err_d);
  end

  // configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_bias_r      <= RST_GYRO_BIAS;
      mag_gain_r       <= RST_MAG_GAIN;
      gain_still_r     <= RST_GAIN_STILL;
      gain_moving_r    <= RST_GAIN_MOVING;
      move_thr_r       <= RST_MOVING_THR;
      outlier_r        <= RST_OUTLIER_LIMIT;
      max_int_r        <= RST_MAX_INTERVAL;
      fused_r          <= '0;
      compass_r        <= '0;
      fused_seeded_r   <= 1'b0;
      compass_seeded_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GYRO_BIAS:        gyro_bias_r   <= cfg_data[BIAS_W-1:0];
          CFG_MAG_FILTER_GAIN:  mag_gain_r    <= cfg_data[GAIN_W-1:0];
          CFG_FUSE_GAIN_STILL:  gain_still_r  <= cfg_data[GAIN_W-1:0];
          CFG_FUSE_GAIN_MOVING: gain_moving_r <= cfg_data[GAIN_W-1:0];
          CFG_MOVING_THRESHOLD: move_thr_r    <= cfg_data[THR_W-1:0];
          CFG_OUTLIER_LIMIT:    outlier_r     <= cfg_data[OUTLIER_W-1:0];
          CFG_MAX_INTERVAL:     max_int_r     <= cfg_data[INTERVAL_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_INTEG: begin
          if (integ_en_r) fused_r <= turn_add(fused_r, step_mod, neg_r);
        end
        OP_JUMP: begin
          if (!compass_seeded_r) begin
            compass_r        <= heading_r;
            compass_seeded_r <= 1'b1;
          end
        end
        OP_CMP_UPD: begin
          if (upd_r) compass_r <= turn_add(compass_r, rnd_mag, dneg_r);
        end
        OP_ERR: begin
          if (!fused_seeded_r) begin
            fused_r        <= compass_r;
            fused_seeded_r <= 1'b1;
          end
        end
        OP_FUSE_UPD: begin
          if (upd_r) fused_r <= turn_add(fused_r, rnd_mag, dneg_r);
        end
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        rate_r     <= rate_sat;
        mag_r      <= mag_nxt;
        neg_r      <= !rate_sat[RATE_W-1] && (rate_sat != '0);
        interval_r <= interval_us;
        present_r  <= compass_present;
        heading_r  <= heading_nxt;
        integ_en_r <= fused_seeded_r && (interval_us != '0) && (interval_us <= max_int_r);
      end
      OP_MUL_RATE, OP_MUL_GAIN: begin
        prod_r <= prod_nxt;
      end
      OP_DIV_STEP: begin
        rem_r <= rem_nxt;
        sh_r  <= sh_nxt;
      end
      OP_JUMP: begin
        dmag_r <= jump_mag;
        dneg_r <= jump_d[SW-1];
        gain_r <= mag_gain_r;
        upd_r  <= compass_seeded_r && (CMP_W'(jump_mag) <= CMP_W'(outlier_r));
      end
      OP_ERR: begin
        dmag_r <= err_mag;
        dneg_r <= err_d[SW-1];
        gain_r <= (mag_r > RATE_W'(move_thr_r)) ? gain_moving_r : gain_still_r;
        upd_r  <= fused_seeded_r;
      end
      OP_OUT_LOAD: begin
        fused_out_r  <= HEAD_W'(fused_r);
        fvalid_out_r <= fused_seeded_r;
        comp_out_r   <= HEAD_W'(compass_r);
        rate_out_r   <= rate_r;
      end
      default: ;
    endcase
  end

  assign stat.integ_en    = integ_en_r;
  assign stat.present     = present_r;
  assign fused_heading    = fused_out_r;
  assign fused_valid      = fvalid_out_r;
  assign filtered_compass = comp_out_r;
  assign corrected_rate   = rate_out_r;

endmodule

`default_nettype wire

// File: rtl/core/hcf_ctrl.sv
// Sequencer of the heading fusion block: walks one word through the
// datapath steps and owns the handshakes. Depends on hcf_pkg.
`default_nettype none

module hcf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output hcf_pkg::dp_cmd_t  cmd,
  input  hcf_pkg::dp_stat_t stat
);
  import hcf_pkg::*;

  ctrl_state_t          state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.div_first = 1'b0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_START;
        end
      end
      S_START: begin
        // branch on what the word needs
        if (stat.integ_en) begin
          cmd.op      = OP_MUL_RATE;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end else if (stat.present) begin
          cmd.op    = OP_JUMP;
          state_nxt = S_MUL_JUMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cmd.op        = OP_DIV_STEP;
        cmd.div_first = (div_cnt_r == '0);
        div_cnt_nxt   = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = S_INTEG;
      end
      S_INTEG: begin
        cmd.op    = OP_INTEG;
        state_nxt = stat.present ? S_JUMP : S_DONE;
      end
      S_JUMP: begin
        cmd.op    = OP_JUMP;
        state_nxt = S_MUL_JUMP;
      end
      S_MUL_JUMP: begin
        cmd.op    = OP_MUL_GAIN;
        state_nxt = S_CMP_UPD;
      end
      S_CMP_UPD: begin
        cmd.op    = OP_CMP_UPD;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.op    = OP_ERR;
        state_nxt = S_MUL_ERR;
      end
      S_MUL_ERR: begin
        cmd.op    = OP_MUL_GAIN;
        state_nxt = S_FUSE_UPD;
      end
      S_FUSE_UPD: begin
        cmd.op    = OP_FUSE_UPD;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/core/heading_complementary_fusion_unit.sv
// Top level of the gyro/compass heading fusion block: sequencer, datapath
// and channel wiring. Depends on hcf_pkg, hcf_channels, hcf_ctrl, hcf_dp.
//
//   channel    dir  carries
//   in_port    in   raw_rate, interval_us, compass_present, compass_heading
//   out_port   out  fused_heading, fused_valid, filtered_compass, corrected_rate
//   cfg_port   in   idx (register code), wdata
//
// One word is in work at a time. A word that neither integrates nor carries a
// compass heading passes only through the start and done states; the bulk of
// the work is the divide by one million, three quotient bits a cycle on a 17
// bit quotient, and the single shared multiplier used three times in turn.
// rst_n is synchronous: it clears the filter state and loads the register
// defaults. A stalled result waits in the output register while the next
// word is taken in; the block only holds at the end of that word's work.
`default_nettype none
`include "assert_macros.svh"

module heading_complementary_fusion_unit #(
  parameter int ANGLE_FRACTION_BITS = hcf_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  hcf_in_if.sink     in_port,
  hcf_out_if.source  out_port,
  hcf_cfg_if.sink    cfg_port
);
  import hcf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready_w;
  logic     in_fire;
  logic     cfg_we;

  // register writes are always taken; the user must send them only while idle, which the block does not enforce
  assign cfg_port.ready = 1'b1;
  assign cfg_we         = cfg_port.valid && cfg_port.ready;

  assign in_port.ready  = in_ready_w;
  assign in_fire        = in_port.valid && in_ready_w;

  // sequencer: one step of the word per state, handshakes on both sides
  hcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_port.valid),
    .in_ready  (in_ready_w),
    .out_valid (out_port.valid),
    .out_ready (out_port.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: registers, multiplier, divider and the result register
  hcf_dp #(
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_port.idx),
    .cfg_data         (cfg_port.wdata),
    .raw_rate         (in_port.raw_rate),
    .interval_us      (in_port.interval_us),
    .compass_present  (in_port.compass_present),
    .compass_heading  (in_port.compass_heading),
    .fused_heading    (out_port.fused_heading),
    .fused_valid      (out_port.fused_valid),
    .filtered_compass (out_port.filtered_compass),
    .corrected_rate   (out_port.corrected_rate)
  );

  // the datapath captures a word exactly when the input handshake completes
  `HCF_ASSERT(a_load_on_accept, clk, rst_n, (cmd.op == OP_LOAD) == in_fire, "load out of step with input handshake")
  // a taken word keeps the input closed on the following cycle
  `HCF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready_w, "input reopened while word in work")
  // the result register is never overwritten while its word waits
  `HCF_ASSERT(a_no_overwrite, clk, rst_n, (cmd.op != OP_OUT_LOAD) || !out_port.valid || out_port.ready, "pending result word overwritten")

endmodule

`default_nettype wire
